[sv/efq_pkg.sv]
// Shared types, field widths and codes for the expedite FIFO queue.
package efq_pkg;

    // Field widths
    localparam int NUM_W   = 14;
    localparam int TAG_W   = 16;
    localparam int OP_W    = 2;
    localparam int ST_W    = 3;
    localparam int TDATA_W = 32;

    // Default queue depth
    localparam int DEFAULT_DEPTH = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE  = 2'd1;
    localparam logic [OP_W-1:0] OP_EXPEDITE = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_DEQUEUED  = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [ST_W-1:0] ST_ENQUEUED  = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_EXPEDITED = 3'd4;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd5;

    // One queue entry as stored
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [TAG_W-1:0] tag;
    } t_entry;

endpackage

[sv/efq_ram.sv]
// Entry storage: one write port and one registered read port.
module efq_ram #(
    parameter int DEPTH = efq_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  efq_pkg::t_entry  i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output efq_pkg::t_entry  o_rd_data
);

    efq_pkg::t_entry r_mem [DEPTH];
    efq_pkg::t_entry r_rd_data;

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read entry into the output register
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/expedite_fifo_queue_unit.sv]
// Top level: ordered queue with expedited front section, run by a small sequencer.
//
//  Channel  Direction  Transfer when              Payload
//  s_axis   in         tvalid & tready            tuser: opcode; tdata: number, origin tag
//  m_axis   out        tvalid & tready            tuser: status; tdata: number, origin tag
//
// Entries sit in a circular buffer; one memory read port and one key comparator
// do all the work. Expedite scans from the head one entry a cycle, then shifts
// the entries behind the expedited section one a cycle.
// Synchronous active-low reset empties the queue; stored entries are not cleared.
// The block takes no new item until the current one finishes; a result waiting
// on m_axis holds the sequencer in its final step only.
module expedite_fifo_queue_unit #(
    parameter int QUEUE_DEPTH = efq_pkg::DEFAULT_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [efq_pkg::TDATA_W-1:0] i_s_axis_tdata,  // [13:0] flight_number, [29:14] origin_tag
    input  logic [efq_pkg::OP_W-1:0]    i_s_axis_tuser,  // [1:0] opcode
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [efq_pkg::TDATA_W-1:0] o_m_axis_tdata,  // [13:0] out_flight_number, [29:14] out_origin_tag
    output logic [efq_pkg::ST_W-1:0]    o_m_axis_tuser   // [2:0] status
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_X   = (AW+1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
    localparam int PAD_W = efq_pkg::TDATA_W - efq_pkg::NUM_W - efq_pkg::TAG_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_DEQ      = 3'd2;
    localparam logic [2:0] S_SEARCH   = 3'd3;
    localparam logic [2:0] S_MV_PRIME = 3'd4;
    localparam logic [2:0] S_MV_SHIFT = 3'd5;
    localparam logic [2:0] S_MV_LAST  = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]                   r_state, n_state;
    logic [efq_pkg::OP_W-1:0]     r_op;
    logic [efq_pkg::NUM_W-1:0]    r_num;
    logic [efq_pkg::TAG_W-1:0]    r_tag;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_exp, n_exp;
    logic [AW-1:0]                r_head, n_head;
    logic [CW-1:0]                r_rd_idx, n_rd_idx;
    logic                         r_cmp_vld, n_cmp_vld;
    logic [CW-1:0]                r_mv_idx, n_mv_idx;
    efq_pkg::t_entry              r_mv_data, n_mv_data;
    logic [efq_pkg::ST_W-1:0]     r_res_status, n_res_status;
    logic [efq_pkg::NUM_W-1:0]    r_res_num, n_res_num;
    logic [efq_pkg::TAG_W-1:0]    r_res_tag, n_res_tag;
    logic                         r_out_valid, n_out_valid;
    logic [efq_pkg::ST_W-1:0]     r_out_status;
    logic [efq_pkg::NUM_W-1:0]    r_out_num;
    logic [efq_pkg::TAG_W-1:0]    r_out_tag;

    logic            in_xfer;
    logic            out_load;
    logic            ram_we;
    logic [AW-1:0]   ram_wr_addr;
    efq_pkg::t_entry ram_wr_data;
    logic [AW-1:0]   ram_rd_addr;
    efq_pkg::t_entry ram_rd_data;
    logic [CW-1:0]   found_pos;

    // Map a queue position to a buffer address
    function automatic logic [AW-1:0] phys(input logic [CW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, r_head} + (AW+1)'(pos);
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    efq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);
    assign found_pos       = r_rd_idx - CW'(1);

    // Sequence one item
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_exp        = r_exp;
        n_head       = r_head;
        n_rd_idx     = r_rd_idx;
        n_cmp_vld    = r_cmp_vld;
        n_mv_idx     = r_mv_idx;
        n_mv_data    = r_mv_data;
        n_res_status = r_res_status;
        n_res_num    = r_res_num;
        n_res_tag    = r_res_tag;
        ram_we       = 1'b0;
        ram_wr_addr  = '0;
        ram_wr_data  = '0;
        ram_rd_addr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res_num = '0;
                n_res_tag = '0;
                n_state   = S_DONE;
                unique case (r_op)
                    efq_pkg::OP_ENQUEUE: begin
                        if (r_count == DEPTH_C) begin
                            n_res_status = efq_pkg::ST_FULL;
                        end else begin
                            ram_we       = 1'b1;
                            ram_wr_addr  = phys(r_count);
                            ram_wr_data  = '{num: r_num, tag: r_tag};
                            n_count      = r_count + CW'(1);
                            n_res_status = efq_pkg::ST_ENQUEUED;
                        end
                    end
                    efq_pkg::OP_DEQUEUE: begin
                        if (r_count == '0) begin
                            n_res_status = efq_pkg::ST_EMPTY;
                        end else begin
                            ram_rd_addr = r_head;
                            n_state     = S_DEQ;
                        end
                    end
                    efq_pkg::OP_EXPEDITE: begin
                        n_rd_idx  = '0;
                        n_cmp_vld = 1'b0;
                        n_state   = S_SEARCH;
                    end
                    default: begin
                        // unused opcode: drop without a result
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DEQ: begin
                n_res_status = efq_pkg::ST_DEQUEUED;
                n_res_num    = ram_rd_data.num;
                n_res_tag    = ram_rd_data.tag;
                n_head       = (r_head == LAST_ADDR) ? '0 : r_head + AW'(1);
                n_count      = r_count - CW'(1);
                if (r_exp != '0) begin
                    n_exp = r_exp - CW'(1);
                end
                n_state = S_DONE;
            end
            S_SEARCH: begin
                // compare the entry read last cycle, issue the next read
                ram_rd_addr = phys(r_rd_idx);
                if (r_cmp_vld && (ram_rd_data.num == r_num)) begin
                    n_mv_data = ram_rd_data;
                    n_mv_idx  = found_pos;
                    n_cmp_vld = 1'b0;
                    if (found_pos < r_exp) begin
                        n_res_status = efq_pkg::ST_EXPEDITED;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_MV_PRIME;
                    end
                end else if (r_rd_idx < r_count) begin
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                end else begin
                    n_cmp_vld    = 1'b0;
                    n_res_status = efq_pkg::ST_NOT_FOUND;
                    n_state      = S_DONE;
                end
            end
            S_MV_PRIME: begin
                if (r_mv_idx == r_exp) begin
                    n_state = S_MV_LAST;
                end else begin
                    ram_rd_addr = phys(r_mv_idx - CW'(1));
                    n_state     = S_MV_SHIFT;
                end
            end
            S_MV_SHIFT: begin
                // move the entry ahead one place back, fetch the next one
                ram_we      = 1'b1;
                ram_wr_addr = phys(r_mv_idx);
                ram_wr_data = ram_rd_data;
                n_mv_idx    = r_mv_idx - CW'(1);
                if ((r_mv_idx - CW'(1)) == r_exp) begin
                    n_state = S_MV_LAST;
                end else begin
                    ram_rd_addr = phys(r_mv_idx - CW'(2));
                end
            end
            S_MV_LAST: begin
                ram_we       = 1'b1;
                ram_wr_addr  = phys(r_exp);
                ram_wr_data  = r_mv_data;
                n_exp        = r_exp + CW'(1);
                n_res_status = efq_pkg::ST_EXPEDITED;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_exp       <= '0;
            r_head      <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_exp       <= n_exp;
            r_head      <= n_head;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold item and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op  <= i_s_axis_tuser;
            r_num <= i_s_axis_tdata[efq_pkg::NUM_W-1:0];
            r_tag <= i_s_axis_tdata[efq_pkg::NUM_W +: efq_pkg::TAG_W];
        end
        r_rd_idx     <= n_rd_idx;
        r_mv_idx     <= n_mv_idx;
        r_mv_data    <= n_mv_data;
        r_res_status <= n_res_status;
        r_res_num    <= n_res_num;
        r_res_tag    <= n_res_tag;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_num    <= r_res_num;
            r_out_tag    <= r_res_tag;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_tag, r_out_num};

endmodule

[sv/efq_checker.sv]
// Port-level checks for the expedite FIFO queue, bound to the top level.
module efq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic [efq_pkg::TDATA_W-1:0] i_s_axis_tdata,
    input logic [efq_pkg::OP_W-1:0]    i_s_axis_tuser,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [efq_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input logic [efq_pkg::ST_W-1:0]    o_m_axis_tuser
);

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Busy right after an input transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while an item is in work");

    // Only a dequeue result carries an entry
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != efq_pkg::ST_DEQUEUED)) |->
            (o_m_axis_tdata == '0))
        else $error("non-dequeue result with nonzero payload");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind expedite_fifo_queue_unit efq_checker u_efq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
